@@ design/ptpd_pkg.sv @@
// shared types and constants for the point to polyline distance core
// command and status codes, datapath command and status records
// no dependencies
`timescale 1ns / 1ps

package ptpd_pkg;

	localparam int MAX_VERTICES_DEF = 4096;
	localparam int COORD_BITS_DEF   = 24;
	localparam int DIST_BITS        = 25;
	localparam int CMD_BITS         = 2;
	localparam int STATUS_BITS      = 3;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 3'd0,
		ST_STORED  = 3'd1,
		ST_FULL    = 3'd2,
		ST_NOGEO   = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	// operand pairs for the shared multiplier
	typedef enum logic [3:0] {
		M_NONE, M_EXEX, M_EYEY, M_VXVX, M_VYVY, M_FXFX, M_FYFY,
		M_EXVX, M_EYVY, M_EXVY, M_EYVX, M_LOLO, M_HILO, M_HIHI
	} mul_sel_t;

	typedef enum logic [1:0] {A_HOLD, A_LOAD, A_ADD, A_SUB} acc_op_t;

	typedef enum logic [2:0] {S_NONE, S_E2, S_LEN2, S_F2, S_DOT, S_CROSS} save_t;

	typedef enum logic [1:0] {D_HOLD, D_LOAD, D_ADD_MID, D_ADD_TOP} dvd_op_t;

	typedef enum logic [1:0] {C_E2, C_F2, C_QUO} cand_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		save_t    save;
		dvd_op_t  dvd_op;
		logic     best_clr;
		logic     load_pt;
		logic     load_cur;
		logic     shift;
		logic     div_init;
		logic     div_step;
		logic     best_upd;
		cand_t    cand;
		logic     sqrt_init;
		logic     sqrt_step;
		logic     out_load;
		status_t  out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic cur_start;
		logic len_zero;
		logic dot_le0;
		logic dot_ge;
	} dp_stat_t;

endpackage

@@ design/ptpd_ram.sv @@
// generic single write port memory with registered read
// no dependencies
`timescale 1ns / 1ps

module ptpd_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/ptpd_dp.sv @@
// datapath: vertex memory, shared multiplier with accumulator, divider, square root
// depends on ptpd_pkg and ptpd_ram
`timescale 1ns / 1ps

module ptpd_dp #(
	parameter int MAX_VERTICES = ptpd_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = ptpd_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ptpd_pkg::dp_cmd_t               dcmd,
	output ptpd_pkg::dp_stat_t              dstat,
	input  logic signed [COORD_BITS-1:0]    coord_x,
	input  logic signed [COORD_BITS-1:0]    coord_y,
	input  logic                            starts_line,
	input  logic                            ram_we,
	input  logic [$clog2(MAX_VERTICES)-1:0] ram_waddr,
	input  logic                            ram_re,
	input  logic [$clog2(MAX_VERTICES)-1:0] ram_raddr,
	output logic [ptpd_pkg::DIST_BITS-1:0]  distance,
	output logic [ptpd_pkg::STATUS_BITS-1:0] status
);

	localparam int C    = COORD_BITS;
	localparam int D    = C + 1;
	localparam int W    = D + 1;
	localparam int PW   = 2 * W;
	localparam int ACCW = 2 * D + 1;
	localparam int QW   = 2 * D;
	localparam int NW   = 4 * D - 2;
	localparam int RW   = 2 * D + 1;
	localparam int VW   = 2 * C + 1;

	logic signed [C-1:0] px_q, py_q, ax_q, ay_q, bx_q, by_q;
	logic                bstart_q;
	logic [VW-1:0]       rdata;

	// vertex store: start flag, y, x
	ptpd_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({starts_line, coord_y, coord_x}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// query point, previous and current vertex
	always_ff @(posedge clk) begin
		if (dcmd.load_pt) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (dcmd.load_cur) begin
			bx_q     <= rdata[C-1:0];
			by_q     <= rdata[2*C-1:C];
			bstart_q <= rdata[VW-1];
		end
		if (dcmd.shift) begin
			ax_q <= bx_q;
			ay_q <= by_q;
		end
	end

	// coordinate differences
	logic signed [D-1:0] ex, ey, vx, vy, fx, fy;
	assign ex = D'(px_q) - D'(ax_q);
	assign ey = D'(py_q) - D'(ay_q);
	assign vx = D'(bx_q) - D'(ax_q);
	assign vy = D'(by_q) - D'(ay_q);
	assign fx = D'(px_q) - D'(bx_q);
	assign fy = D'(py_q) - D'(by_q);

	logic signed [ACCW-1:0] acc_q, dot_q, cross_q, crm;
	logic [QW-1:0]          e2_q, f2_q, len2_q;
	logic [D-1:0]           cr_hi, cr_lo;

	// magnitude of the cross product split in two halves
	assign crm   = cross_q[ACCW-1] ? -cross_q : cross_q;
	assign cr_hi = crm[QW-1:D];
	assign cr_lo = crm[D-1:0];

	// multiplier operand selection
	logic signed [W-1:0] ma, mb;
	always_comb begin
		case (dcmd.mul_sel)
			ptpd_pkg::M_EXEX: begin ma = W'(ex); mb = W'(ex); end
			ptpd_pkg::M_EYEY: begin ma = W'(ey); mb = W'(ey); end
			ptpd_pkg::M_VXVX: begin ma = W'(vx); mb = W'(vx); end
			ptpd_pkg::M_VYVY: begin ma = W'(vy); mb = W'(vy); end
			ptpd_pkg::M_FXFX: begin ma = W'(fx); mb = W'(fx); end
			ptpd_pkg::M_FYFY: begin ma = W'(fy); mb = W'(fy); end
			ptpd_pkg::M_EXVX: begin ma = W'(ex); mb = W'(vx); end
			ptpd_pkg::M_EYVY: begin ma = W'(ey); mb = W'(vy); end
			ptpd_pkg::M_EXVY: begin ma = W'(ex); mb = W'(vy); end
			ptpd_pkg::M_EYVX: begin ma = W'(ey); mb = W'(vx); end
			ptpd_pkg::M_LOLO: begin ma = $signed({1'b0, cr_lo}); mb = $signed({1'b0, cr_lo}); end
			ptpd_pkg::M_HILO: begin ma = $signed({1'b0, cr_hi}); mb = $signed({1'b0, cr_lo}); end
			ptpd_pkg::M_HIHI: begin ma = $signed({1'b0, cr_hi}); mb = $signed({1'b0, cr_hi}); end
			default:          begin ma = '0; mb = '0; end
		endcase
	end

	logic signed [PW-1:0]   prod_q;
	logic signed [ACCW-1:0] pe;
	logic [QW-1:0]          pu;
	assign pe = $signed(prod_q[ACCW-1:0]);
	assign pu = prod_q[QW-1:0];

	// multiplier, accumulator and saved terms
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (dcmd.acc_op)
			ptpd_pkg::A_LOAD: acc_q <= pe;
			ptpd_pkg::A_ADD:  acc_q <= acc_q + pe;
			ptpd_pkg::A_SUB:  acc_q <= acc_q - pe;
			default:          acc_q <= acc_q;
		endcase
		case (dcmd.save)
			ptpd_pkg::S_E2:    e2_q    <= acc_q[QW-1:0];
			ptpd_pkg::S_LEN2:  len2_q  <= acc_q[QW-1:0];
			ptpd_pkg::S_F2:    f2_q    <= acc_q[QW-1:0];
			ptpd_pkg::S_DOT:   dot_q   <= acc_q;
			ptpd_pkg::S_CROSS: cross_q <= acc_q;
			default: ;
		endcase
	end

	// segment classification
	assign dstat.cur_start = bstart_q;
	assign dstat.len_zero  = (len2_q == '0);
	assign dstat.dot_le0   = dot_q[ACCW-1] || (dot_q == '0);
	assign dstat.dot_ge    = !dot_q[ACCW-1] && (dot_q[QW-1:0] >= len2_q);

	// squared cross product, then restoring division by the squared length
	logic [NW-1:0] dvd_q;
	logic [RW-1:0] rem_q, rsh;
	logic [QW-1:0] dlow_q, quo_q;
	assign rsh = {rem_q[RW-2:0], dlow_q[QW-1]};

	always_ff @(posedge clk) begin
		case (dcmd.dvd_op)
			ptpd_pkg::D_LOAD:    dvd_q <= NW'(pu);
			ptpd_pkg::D_ADD_MID: dvd_q <= dvd_q + (NW'(pu) << (D + 1));
			ptpd_pkg::D_ADD_TOP: dvd_q <= dvd_q + (NW'(pu) << QW);
			default:             dvd_q <= dvd_q;
		endcase
		if (dcmd.div_init) begin
			rem_q  <= RW'(dvd_q[NW-1:QW]);
			dlow_q <= dvd_q[QW-1:0];
			quo_q  <= '0;
		end else if (dcmd.div_step) begin
			dlow_q <= {dlow_q[QW-2:0], 1'b0};
			if (rsh >= RW'(len2_q)) begin
				rem_q <= rsh - RW'(len2_q);
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rsh;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	// running minimum
	logic [QW-1:0] cand, best_q;
	logic          have_q;
	always_comb begin
		case (dcmd.cand)
			ptpd_pkg::C_F2:  cand = f2_q;
			ptpd_pkg::C_QUO: cand = quo_q;
			default:         cand = e2_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (dcmd.best_clr) begin
			have_q <= 1'b0;
		end else if (dcmd.best_upd) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.best_upd && (!have_q || cand < best_q)) begin
			best_q <= cand;
		end
	end

	// digit by digit integer square root
	logic [QW-1:0] sop_q, sres_q, sone_q, strial;
	assign strial = sres_q + sone_q;

	always_ff @(posedge clk) begin
		if (dcmd.sqrt_init) begin
			sop_q  <= best_q;
			sres_q <= '0;
			sone_q <= QW'(1) << (QW - 2);
		end else if (dcmd.sqrt_step) begin
			if (sop_q >= strial) begin
				sop_q  <= sop_q - strial;
				sres_q <= (sres_q >> 1) + sone_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sone_q <= sone_q >> 2;
		end
	end

	// result register
	logic [ptpd_pkg::DIST_BITS-1:0] dsat;
	assign dsat = (sres_q > QW'(ptpd_pkg::DIST_MAX)) ? ptpd_pkg::DIST_MAX
		: sres_q[ptpd_pkg::DIST_BITS-1:0];

	always_ff @(posedge clk) begin
		if (dcmd.out_load) begin
			distance <= (dcmd.out_status == ptpd_pkg::ST_OK) ? dsat : '0;
			status   <= dcmd.out_status;
		end
	end

endmodule

@@ design/ptpd_ctrl.sv @@
// controller: command decode, vertex count, query walk sequencer, output handshake
// depends on ptpd_pkg
`timescale 1ns / 1ps

module ptpd_ctrl #(
	parameter int MAX_VERTICES = ptpd_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = ptpd_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ptpd_pkg::CMD_BITS-1:0]   cmd,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ptpd_pkg::dp_cmd_t               dcmd,
	input  ptpd_pkg::dp_stat_t              dstat,
	output logic                            ram_we,
	output logic [$clog2(MAX_VERTICES)-1:0] ram_waddr,
	output logic                            ram_re,
	output logic [$clog2(MAX_VERTICES)-1:0] ram_raddr
);

	localparam int D  = COORD_BITS + 1;
	localparam int QW = 2 * D;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int SW = $clog2(QW);
	localparam logic [SW-1:0] MAC_LAST  = SW'(11);
	localparam logic [SW-1:0] SQ_LAST   = SW'(3);
	localparam logic [SW-1:0] DIV_LAST  = SW'(QW - 1);
	localparam logic [SW-1:0] ROOT_LAST = SW'(D - 1);

	typedef enum logic [3:0] {
		IDLE, Q_WAIT, Q_EVAL, MAC, DECIDE, SQ, DIV_INIT, DIV, UPD, SHIFT,
		ROOT_INIT, ROOT, DONE
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q, idx_q, nidx;
	logic [SW-1:0]     cnt_q;
	logic              single_q, end_q, pbegin_q, begin_q, out_valid_q;
	ptpd_pkg::cand_t   cand_q;
	ptpd_pkg::status_t ost_q;
	logic              accept, full, can_load, b;

	assign accept   = in_valid && (state_q == IDLE);
	assign in_stall = (state_q != IDLE);
	assign full     = (count_q >= CW'(MAX_VERTICES));
	assign nidx     = idx_q + 1'b1;
	assign can_load = !out_valid_q || !out_stall;
	assign b        = (idx_q == '0) || dstat.cur_start;
	assign out_valid = out_valid_q;

	// memory access
	assign ram_we    = accept && (cmd == ptpd_pkg::CMD_APPEND) && !full;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_re    = (accept && (cmd == ptpd_pkg::CMD_QUERY) && (count_q != '0))
		|| ((state_q == SHIFT) && (nidx < count_q));
	assign ram_raddr = (state_q == IDLE) ? '0 : nidx[AW-1:0];

	// datapath commands
	always_comb begin
		dcmd            = '0;
		dcmd.mul_sel    = ptpd_pkg::M_NONE;
		dcmd.acc_op     = ptpd_pkg::A_HOLD;
		dcmd.save       = ptpd_pkg::S_NONE;
		dcmd.dvd_op     = ptpd_pkg::D_HOLD;
		dcmd.cand       = cand_q;
		dcmd.out_status = ost_q;
		dcmd.load_pt    = accept;
		dcmd.best_clr   = accept && (cmd == ptpd_pkg::CMD_QUERY);
		dcmd.load_cur   = (state_q == Q_WAIT);
		dcmd.shift      = (state_q == SHIFT);
		dcmd.div_init   = (state_q == DIV_INIT);
		dcmd.div_step   = (state_q == DIV);
		dcmd.best_upd   = (state_q == UPD);
		dcmd.sqrt_init  = (state_q == ROOT_INIT);
		dcmd.sqrt_step  = (state_q == ROOT);
		dcmd.out_load   = (state_q == DONE) && can_load;
		if (state_q == MAC) begin
			case (cnt_q)
				SW'(0):  dcmd.mul_sel = ptpd_pkg::M_EXEX;
				SW'(1):  begin dcmd.mul_sel = ptpd_pkg::M_EYEY; dcmd.acc_op = ptpd_pkg::A_LOAD; end
				SW'(2):  begin dcmd.mul_sel = ptpd_pkg::M_VXVX; dcmd.acc_op = ptpd_pkg::A_ADD; end
				SW'(3):  begin
					dcmd.mul_sel = ptpd_pkg::M_VYVY; dcmd.acc_op = ptpd_pkg::A_LOAD;
					dcmd.save = ptpd_pkg::S_E2;
				end
				SW'(4):  begin dcmd.mul_sel = ptpd_pkg::M_FXFX; dcmd.acc_op = ptpd_pkg::A_ADD; end
				SW'(5):  begin
					dcmd.mul_sel = ptpd_pkg::M_FYFY; dcmd.acc_op = ptpd_pkg::A_LOAD;
					dcmd.save = ptpd_pkg::S_LEN2;
				end
				SW'(6):  begin dcmd.mul_sel = ptpd_pkg::M_EXVX; dcmd.acc_op = ptpd_pkg::A_ADD; end
				SW'(7):  begin
					dcmd.mul_sel = ptpd_pkg::M_EYVY; dcmd.acc_op = ptpd_pkg::A_LOAD;
					dcmd.save = ptpd_pkg::S_F2;
				end
				SW'(8):  begin dcmd.mul_sel = ptpd_pkg::M_EXVY; dcmd.acc_op = ptpd_pkg::A_ADD; end
				SW'(9):  begin
					dcmd.mul_sel = ptpd_pkg::M_EYVX; dcmd.acc_op = ptpd_pkg::A_LOAD;
					dcmd.save = ptpd_pkg::S_DOT;
				end
				SW'(10): dcmd.acc_op = ptpd_pkg::A_SUB;
				default: dcmd.save = ptpd_pkg::S_CROSS;
			endcase
		end
		if (state_q == SQ) begin
			case (cnt_q)
				SW'(0): dcmd.mul_sel = ptpd_pkg::M_LOLO;
				SW'(1): begin dcmd.mul_sel = ptpd_pkg::M_HILO; dcmd.dvd_op = ptpd_pkg::D_LOAD; end
				SW'(2): begin dcmd.mul_sel = ptpd_pkg::M_HIHI; dcmd.dvd_op = ptpd_pkg::D_ADD_MID; end
				default: dcmd.dvd_op = ptpd_pkg::D_ADD_TOP;
			endcase
		end
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			single_q    <= 1'b0;
			end_q       <= 1'b0;
			pbegin_q    <= 1'b0;
			begin_q     <= 1'b0;
			cand_q      <= ptpd_pkg::C_E2;
			ost_q       <= ptpd_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set on a result load, cleared once taken
			if ((state_q == DONE) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						case (cmd)
							ptpd_pkg::CMD_CLEAR: begin
								count_q <= '0;
								ost_q   <= ptpd_pkg::ST_CLEARED;
								state_q <= DONE;
							end
							ptpd_pkg::CMD_APPEND: begin
								if (full) begin
									ost_q <= ptpd_pkg::ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
									ost_q   <= ptpd_pkg::ST_STORED;
								end
								state_q <= DONE;
							end
							ptpd_pkg::CMD_QUERY: begin
								if (count_q == '0) begin
									ost_q   <= ptpd_pkg::ST_NOGEO;
									state_q <= DONE;
								end else begin
									idx_q    <= '0;
									pbegin_q <= 1'b0;
									state_q  <= Q_WAIT;
								end
							end
							default: state_q <= IDLE;
						endcase
					end
				end
				Q_WAIT: state_q <= Q_EVAL;
				Q_EVAL: begin
					begin_q <= b;
					cnt_q   <= '0;
					end_q   <= 1'b0;
					if (!b) begin
						single_q <= 1'b0;
						state_q  <= MAC;
					end else if ((idx_q != '0) && pbegin_q) begin
						single_q <= 1'b1;
						state_q  <= MAC;
					end else begin
						state_q <= SHIFT;
					end
				end
				MAC: begin
					if (cnt_q == MAC_LAST) begin
						cnt_q   <= '0;
						state_q <= DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DECIDE: begin
					cnt_q <= '0;
					if (single_q || dstat.len_zero || dstat.dot_le0) begin
						cand_q  <= ptpd_pkg::C_E2;
						state_q <= UPD;
					end else if (dstat.dot_ge) begin
						cand_q  <= ptpd_pkg::C_F2;
						state_q <= UPD;
					end else begin
						state_q <= SQ;
					end
				end
				SQ: begin
					if (cnt_q == SQ_LAST) begin
						state_q <= DIV_INIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DIV_INIT: begin
					cnt_q   <= '0;
					cand_q  <= ptpd_pkg::C_QUO;
					state_q <= DIV;
				end
				DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= UPD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				UPD: state_q <= end_q ? ROOT_INIT : SHIFT;
				SHIFT: begin
					pbegin_q <= begin_q;
					if (nidx < count_q) begin
						idx_q   <= nidx;
						state_q <= Q_WAIT;
					end else if (begin_q) begin
						single_q <= 1'b1;
						end_q    <= 1'b1;
						cnt_q    <= '0;
						state_q  <= MAC;
					end else begin
						state_q <= ROOT_INIT;
					end
				end
				ROOT_INIT: begin
					cnt_q   <= '0;
					state_q <= ROOT;
				end
				ROOT: begin
					if (cnt_q == ROOT_LAST) begin
						ost_q   <= ptpd_pkg::ST_OK;
						state_q <= DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DONE: begin
					if (can_load) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_VERTICES))
		else $error("vertex count beyond table size");

	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == Q_WAIT || state_q == Q_EVAL) |-> idx_q < count_q)
		else $error("walk index beyond stored vertices");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> count_q < CW'(MAX_VERTICES))
		else $error("vertex write into a full table");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == ptpd_pkg::CMD_CLEAR) |=> count_q == '0)
		else $error("clear request left vertices");
`endif

endmodule

@@ design/point_to_polyline_distance_core.sv @@
// top level of the point to polyline distance core
// depends on ptpd_pkg, ptpd_ctrl, ptpd_dp (and ptpd_ram through ptpd_dp)
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid/in_stall) carries one request: cmd, coord_x, coord_y,
// starts_line. cmd clear empties the vertex table, append stores a vertex,
// query returns the floored distance from the point to the nearest segment or lone vertex.
// Output channel (out_valid/out_stall) returns distance and status, one
// result per request; an unused cmd code is dropped without a result.
// Clear and append go from IDLE to DONE and load the result register. A query walks the
// table through one memory read port and one shared multiplier: each
// measured vertex takes a multiply-accumulate pass (a line start that is
// skipped takes none), a segment whose projection falls inside it adds a
// long division, and a final square root ends the walk. One request is
// worked on at a time; in_stall is high until the result is loaded into
// the output register.
// When the receiver stalls, the result holds in the output register and a new
// request is still taken; a second result waits until the first is taken.
// Reset empties the table (vertex count zero) and clears out_valid; memory
// contents are left as they are.

module point_to_polyline_distance_core #(
	parameter int MAX_VERTICES = ptpd_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = ptpd_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ptpd_pkg::CMD_BITS-1:0]    cmd,
	input  logic signed [COORD_BITS-1:0]     coord_x,
	input  logic signed [COORD_BITS-1:0]     coord_y,
	input  logic                             starts_line,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ptpd_pkg::DIST_BITS-1:0]   distance,
	output logic [ptpd_pkg::STATUS_BITS-1:0] status
);

	localparam int AW = $clog2(MAX_VERTICES);

	ptpd_pkg::dp_cmd_t  dcmd;
	ptpd_pkg::dp_stat_t dstat;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;

	// sequencer
	ptpd_ctrl #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dcmd     (dcmd),
		.dstat    (dstat),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr)
	);

	// arithmetic and vertex store
	ptpd_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dcmd       (dcmd),
		.dstat      (dstat),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.starts_line(starts_line),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.distance   (distance),
		.status     (status)
	);

endmodule

@@ bench/point_to_polyline_distance_core_tb.sv @@
// self-checking bench for the point to polyline distance core
// predicts every result in exact integer arithmetic, checks it field by field
// depends on ptpd_pkg and point_to_polyline_distance_core
`timescale 1ns / 1ps

module point_to_polyline_distance_core_tb;

	localparam int NVERT = ptpd_pkg::MAX_VERTICES_DEF;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_AT = 20;
	localparam int HOLD_LEN = 300;
	localparam int CALM_FROM = 3000;
	localparam int CALM_TO = 9000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RAND_ITEMS = 115;
	localparam logic [ptpd_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [ptpd_pkg::CMD_BITS-1:0] op;
		logic signed [23:0]  x;
		logic signed [23:0]  y;
		logic                sl;
		bit                  sync;
	} request_t;

	typedef struct {
		logic [ptpd_pkg::DIST_BITS-1:0] dval;
		ptpd_pkg::status_t              st;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ptpd_pkg::CMD_BITS-1:0] cmd = ptpd_pkg::CMD_CLEAR;
	logic signed [23:0] coord_x = '0;
	logic signed [23:0] coord_y = '0;
	logic starts_line = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ptpd_pkg::DIST_BITS-1:0] distance;
	logic [ptpd_pkg::STATUS_BITS-1:0] status;

	request_t pending_q[$];
	answer_t  answer_q[$];
	bit       failed = 1'b0;
	int       cycle = 0;
	int       accepted = 0;
	int       hold_left = 0;
	bit       held = 1'b0;

	// shadow copy of the vertex table
	longint   tab_x[NVERT];
	longint   tab_y[NVERT];
	bit       tab_start[NVERT];
	int       tab_count = 0;

	point_to_polyline_distance_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .coord_x(coord_x), .coord_y(coord_y), .starts_line(starts_line),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [127:0] mag128(longint v);
		longint a;
		a = v < 0 ? -v : v;
		return {64'd0, a};
	endfunction

	function automatic logic [127:0] pt_sq(longint dx, longint dy);
		return mag128(dx * dx + dy * dy);
	endfunction

	// floored squared distance from a point to segment ia-ib, projection clamped
	function automatic logic [127:0] seg_sq(longint px, longint py, int ia, int ib);
		longint ex, ey, vx, vy, len2, dotp, cr;
		logic [127:0] c2;
		ex = px - tab_x[ia];
		ey = py - tab_y[ia];
		vx = tab_x[ib] - tab_x[ia];
		vy = tab_y[ib] - tab_y[ia];
		len2 = vx * vx + vy * vy;
		if (len2 == 0)
			return pt_sq(ex, ey);
		dotp = ex * vx + ey * vy;
		if (dotp <= 0)
			return pt_sq(ex, ey);
		if (dotp >= len2)
			return pt_sq(px - tab_x[ib], py - tab_y[ib]);
		cr = ex * vy - ey * vx;
		c2 = mag128(cr);
		c2 = c2 * c2;
		return c2 / mag128(len2);
	endfunction

	function automatic bit line_head(int i);
		return i == 0 || tab_start[i];
	endfunction

	function automatic logic [63:0] floor_root(logic [127:0] v);
		logic [127:0] res, c;
		res = '0;
		for (int b = 31; b >= 0; b--) begin
			c = res | (128'd1 << b);
			if (c * c <= v)
				res = c;
		end
		return res[63:0];
	endfunction

	// apply one request to the shadow table, give the expected answer if any
	function automatic bit predict_answer(request_t r, output answer_t a);
		logic [127:0] best, d2;
		bit have;
		a.dval = '0;
		case (r.op)
			ptpd_pkg::CMD_CLEAR: begin
				tab_count = 0;
				a.st = ptpd_pkg::ST_CLEARED;
			end
			ptpd_pkg::CMD_APPEND: begin
				if (tab_count >= NVERT) begin
					a.st = ptpd_pkg::ST_FULL;
				end else begin
					tab_x[tab_count] = r.x;
					tab_y[tab_count] = r.y;
					tab_start[tab_count] = r.sl;
					tab_count++;
					a.st = ptpd_pkg::ST_STORED;
				end
			end
			ptpd_pkg::CMD_QUERY: begin
				if (tab_count == 0) begin
					a.st = ptpd_pkg::ST_NOGEO;
				end else begin
					have = 0;
					best = '0;
					for (int i = 0; i < tab_count; i++) begin
						if (line_head(i) && (i + 1 >= tab_count || line_head(i + 1)))
							d2 = pt_sq(r.x - tab_x[i], r.y - tab_y[i]);
						else if (!line_head(i))
							d2 = seg_sq(r.x, r.y, i - 1, i);
						else
							continue;
						if (!have || d2 < best)
							best = d2;
						have = 1;
					end
					a.dval = ptpd_pkg::DIST_BITS'(floor_root(best));
					a.st = ptpd_pkg::ST_OK;
				end
			end
			default: return 0;
		endcase
		return 1;
	endfunction

	function automatic bit idle_now();
		return !(cycle >= CALM_FROM && cycle < CALM_TO) && $urandom_range(99) < 12;
	endfunction

	// driver: present pending requests, predict each accepted one
	always @(posedge clk) begin
		answer_t a;
		bit busy;
		busy = in_valid;
		if (in_valid && !in_stall) begin
			if (predict_answer(pending_q[0], a))
				answer_q.push_back(a);
			void'(pending_q.pop_front());
			accepted++;
			busy = 0;
		end
		if (!busy && arst_n) begin
			if (pending_q.size() > 0 && !idle_now()
					&& !(pending_q[0].sync && answer_q.size() > 0)) begin
				in_valid <= 1'b1;
				cmd <= pending_q[0].op;
				coord_x <= pending_q[0].x;
				coord_y <= pending_q[0].y;
				starts_line <= pending_q[0].sl;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		answer_t a;
		if (out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				$error("unexpected result distance=%0d status=%0d", distance, status);
				failed = 1'b1;
			end else begin
				a = answer_q.pop_front();
				if (distance !== a.dval) begin
					$error("distance expected %0d actual %0d", a.dval, distance);
					failed = 1'b1;
				end
				if (status !== a.st) begin
					$error("status expected %0d actual %0d", a.st, status);
					failed = 1'b1;
				end
			end
		end
		// one long receiver hold-off, otherwise random stalls
		if (!held && accepted >= HOLD_AT) begin
			held = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_now();
		end
	end

	// cycle counter and run limit
	always @(posedge clk) begin
		cycle++;
		if (cycle > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic add_req(logic [ptpd_pkg::CMD_BITS-1:0] op, longint x, longint y, bit sl,
			bit sync = 0);
		request_t r;
		r.op = op;
		r.x = 24'(x);
		r.y = 24'(y);
		r.sl = sl;
		r.sync = sync;
		pending_q.push_back(r);
	endtask

	function automatic longint rand_coord(bit wide_range, longint cx);
		if (wide_range)
			return longint'($signed(24'($urandom)));
		return cx + $signed($urandom_range(800)) - 400;
	endfunction

	initial begin
		int rows;
		int k;
		bit wr;
		longint cx, cy;
		// directed: empty query, first vertex unmarked, single points, extremes
		add_req(ptpd_pkg::CMD_QUERY, 5, -5, 0);
		add_req(ptpd_pkg::CMD_CLEAR, 0, 0, 0);
		add_req(ptpd_pkg::CMD_APPEND, 8388607, 8388607, 0);
		add_req(ptpd_pkg::CMD_QUERY, -8388608, -8388608, 1);
		add_req(ptpd_pkg::CMD_APPEND, 100, 100, 1);
		add_req(ptpd_pkg::CMD_APPEND, 100, 100, 0);
		add_req(ptpd_pkg::CMD_QUERY, 100, 200, 0);
		add_req(ptpd_pkg::CMD_APPEND, 1000, 100, 0);
		add_req(ptpd_pkg::CMD_QUERY, 500, 137, 0);
		add_req(ptpd_pkg::CMD_QUERY, 2000, -50, 0);
		add_req(ptpd_pkg::CMD_QUERY, -300, 90, 0);
		add_req(ptpd_pkg::CMD_APPEND, -8388608, 8388607, 1);
		add_req(ptpd_pkg::CMD_APPEND, 8388607, -8388608, 0);
		add_req(ptpd_pkg::CMD_QUERY, 3, 7, 0);
		add_req(CMD_UNUSED, -1, -1, 1);
		add_req(ptpd_pkg::CMD_APPEND, 0, 0, 1);
		add_req(ptpd_pkg::CMD_QUERY, 0, 0, 0);
		add_req(ptpd_pkg::CMD_CLEAR, 0, 0, 0);
		add_req(ptpd_pkg::CMD_QUERY, 1, 1, 0);
		add_req(ptpd_pkg::CMD_APPEND, -5, 9, 1, 1);
		add_req(ptpd_pkg::CMD_QUERY, -8388608, 8388607, 0);

		// random: mostly lines around a local center, some wide and noise requests
		rows = 0;
		k = 0;
		cx = 0;
		cy = 0;
		while (k < RAND_ITEMS) begin
			int pick;
			pick = $urandom_range(99);
			wr = $urandom_range(99) < 20;
			if (pick < 3 || rows > 40) begin
				add_req(ptpd_pkg::CMD_CLEAR, rand_coord(1, 0), rand_coord(1, 0),
					$urandom_range(1), $urandom_range(99) < 30);
				rows = 0;
				cx = rand_coord(1, 0) / 2;
				cy = rand_coord(1, 0) / 2;
			end else if (pick < 55) begin
				add_req(ptpd_pkg::CMD_APPEND, rand_coord(wr, cx), rand_coord(wr, cy),
					$urandom_range(99) < 20);
				rows++;
			end else if (pick < 95) begin
				add_req(ptpd_pkg::CMD_QUERY, rand_coord(wr, cx), rand_coord(wr, cy),
					$urandom_range(1));
			end else begin
				add_req(CMD_UNUSED, rand_coord(1, 0), rand_coord(1, 0), $urandom_range(1));
				continue;
			end
			k++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() > 0 || in_valid || answer_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
